// ===== hdl/flag_byte_stuffing_framer_defines.svh =====
// Assertion macros for the flag byte stuffing framer.
// Used by the queue and back-end modules; empty when SYNTHESIS is defined.
`ifndef FLAG_BYTE_STUFFING_FRAMER_DEFINES_SVH
`define FLAG_BYTE_STUFFING_FRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define FBSF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fbsf assertion failed");
`define FBSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbsf implication failed");
`else
`define FBSF_ASSERT(label, clk, rst_n, prop)
`define FBSF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/fbsf_pkg.sv =====
// Package for the flag byte stuffing framer: payload types, framing constants.
// No dependencies.
package fbsf_pkg;

  localparam logic [7:0] FlagByte  = 8'h7E;
  localparam logic [7:0] EscByte   = 8'h7D;
  localparam logic [7:0] EscXor    = 8'h20;
  localparam int         QDepthDef = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       empty_packet;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       frame_end;
  } out_t;

  // Pending output pieces of one request, emitted in field order.
  typedef struct packed {
    logic       open_flag;
    logic       esc;
    logic       body;
    logic       close_flag;
    logic [7:0] body_byte;
  } desc_t;

endpackage

// ===== hdl/fbsf_front.sv =====
// Front end: accepts input requests and classifies them into descriptors.
// Depends on fbsf_pkg.
module fbsf_front import fbsf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_i,
  output logic  d_vld_o,
  input  logic  d_rdy_i,
  output desc_t d_o
);

  logic  vld_q;
  desc_t desc_d, desc_q;
  logic  is_special;

  assign in_ready_o = !vld_q || d_rdy_i;
  assign is_special = (in_i.data_byte == FlagByte) || (in_i.data_byte == EscByte);

  always_comb begin
    desc_d = '0;
    if (in_i.empty_packet) begin
      desc_d.open_flag  = 1'b1;
      desc_d.close_flag = 1'b1;
    end else begin
      desc_d.open_flag  = in_i.first_of_packet;
      desc_d.esc        = is_special;
      desc_d.body       = 1'b1;
      desc_d.close_flag = in_i.last_of_packet;
      desc_d.body_byte  = is_special ? (in_i.data_byte ^ EscXor) : in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      desc_q <= desc_d;
    end
  end

  assign d_vld_o = vld_q;
  assign d_o     = desc_q;

endmodule

// ===== hdl/fbsf_queue.sv =====
// Descriptor queue between front and back end, register-file FIFO.
// Depends on fbsf_pkg and the framer assertion macros.
`include "flag_byte_stuffing_framer_defines.svh"
module fbsf_queue import fbsf_pkg::*; #(
  parameter int Depth = QDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  ready_o,
  input  desc_t desc_i,
  output logic  vld_o,
  input  logic  pop_i,
  output desc_t desc_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  desc_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             full, do_push, do_pop;

  assign full    = (cnt_q == CntW'(Depth));
  assign ready_o = !full;
  assign vld_o   = (cnt_q != '0);
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && vld_o;
  assign desc_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= desc_i;
    end
  end

  `FBSF_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(Depth))
  `FBSF_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop_i, vld_o)
  `FBSF_ASSERT_IMPL(a_cnt_track, clk_i, rst_ni, do_push && !do_pop, ##1 cnt_q == $past(cnt_q) + 1'b1)

endmodule

// ===== hdl/fbsf_back.sv =====
// Back end: expands descriptors into framed bytes through an output register.
// Depends on fbsf_pkg and the framer assertion macros.
`include "flag_byte_stuffing_framer_defines.svh"
module fbsf_back import fbsf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_vld_i,
  input  desc_t q_desc_i,
  output logic  q_pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_o
);

  logic  busy_q, out_vld_q;
  desc_t rem_q, cur, nxt;
  out_t  out_q, res;
  logic  cur_vld, load, more;

  assign cur     = busy_q ? rem_q : q_desc_i;
  assign cur_vld = busy_q || q_vld_i;
  assign load    = cur_vld && (!out_vld_q || out_ready_i);
  assign q_pop_o = load && !busy_q;

  always_comb begin
    nxt = cur;
    res = '0;
    if (cur.open_flag) begin
      res.out_byte  = FlagByte;
      nxt.open_flag = 1'b0;
    end else if (cur.esc) begin
      res.out_byte = EscByte;
      nxt.esc      = 1'b0;
    end else if (cur.body) begin
      res.out_byte = cur.body_byte;
      nxt.body     = 1'b0;
    end else begin
      res.out_byte   = FlagByte;
      res.frame_end  = 1'b1;
      nxt.close_flag = 1'b0;
    end
    more        = nxt.open_flag || nxt.esc || nxt.body || nxt.close_flag;
    res.run_end = !more;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (load) begin
      busy_q    <= more;
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q <= nxt;
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  `FBSF_ASSERT_IMPL(a_fend_flag, clk_i, rst_ni, out_vld_q && out_q.frame_end, out_q.out_byte == FlagByte && out_q.run_end)
  `FBSF_ASSERT_IMPL(a_busy_work, clk_i, rst_ni, busy_q, rem_q.open_flag || rem_q.esc || rem_q.body || rem_q.close_flag)
  `FBSF_ASSERT_IMPL(a_busy_no_pop, clk_i, rst_ni, busy_q, !q_pop_o)

endmodule

// ===== hdl/flag_byte_stuffing_framer.sv =====
// An accepted request passes the front register, descriptor queue and output
// register before its first result is valid. Throughput: one request per
// cycle while the queue has room; the back end emits 1 to 4 bytes per request.
// Reset (rst_ni, async, active low) empties the front register, queue and
// output register; the block is ready right after reset.
module flag_byte_stuffing_framer import fbsf_pkg::*; #(
  parameter int QDepth = QDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic  f_vld, q_rdy, q_vld, q_pop;
  desc_t f_desc, q_desc;

  fbsf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .d_vld_o    (f_vld),
    .d_rdy_i    (q_rdy),
    .d_o        (f_desc)
  );

  fbsf_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_vld),
    .ready_o (q_rdy),
    .desc_i  (f_desc),
    .vld_o   (q_vld),
    .pop_i   (q_pop),
    .desc_o  (q_desc)
  );

  fbsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_desc_i    (q_desc),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
